### rtl/tpd_pkg.sv
package tpd_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int TMO_W     = 16;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_W     = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ASK    = 2'd1;
  localparam logic [OP_W-1:0] OP_SUBMIT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

  localparam logic [REG_W-1:0] REG_MAP_CNT = 2'd0;
  localparam logic [REG_W-1:0] REG_RED_CNT = 2'd1;
  localparam logic [REG_W-1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic inc_idx;
    logic grant;
    logic load_out;
  } tpd_cmd_t;

  typedef struct packed {
    logic is_ask;
    logic pending;
    logic hit;
    logic last;
  } tpd_sts_t;

endpackage

### rtl/tpd_regs.sv
module tpd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpd_pkg::DATA_W-1:0]  pwdata,
  output logic [tpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [tpd_pkg::CNT_W-1:0]   map_cnt_o,
  output logic [tpd_pkg::CNT_W-1:0]   red_cnt_o,
  output logic [tpd_pkg::TMO_W-1:0]   timeout_o
);
  import tpd_pkg::*;

  logic [CNT_W-1:0] map_cnt_q;
  logic [CNT_W-1:0] red_cnt_q;
  logic [TMO_W-1:0] timeout_q;
  logic [REG_W-1:0] reg_sel;
  logic             wr_en;

  assign reg_sel = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cnt_q <= '0;
      red_cnt_q <= '0;
      timeout_q <= TMO_W'(50);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MAP_CNT: map_cnt_q <= pwdata[CNT_W-1:0];
        REG_RED_CNT: red_cnt_q <= pwdata[CNT_W-1:0];
        REG_TIMEOUT: timeout_q <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAP_CNT: prdata = DATA_W'(map_cnt_q);
      REG_RED_CNT: prdata = DATA_W'(red_cnt_q);
      REG_TIMEOUT: prdata = DATA_W'(timeout_q);
      default:     prdata = '0;
    endcase
  end

  assign map_cnt_o = map_cnt_q;
  assign red_cnt_o = red_cnt_q;
  assign timeout_o = timeout_q;

endmodule

### rtl/tpd_ctrl.sv
module tpd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tpd_pkg::tpd_sts_t sts_i,
  output tpd_pkg::tpd_cmd_t cmd_o
);
  import tpd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (sts_i.is_ask && sts_i.pending) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.grant = 1'b1;
          state_d     = S_DONE;
        end else if (sts_i.last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_DONE: begin
        // result register frees up in the same cycle it is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### rtl/tpd_dp.sv
module tpd_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tpd_pkg::tpd_cmd_t           cmd_i,
  output tpd_pkg::tpd_sts_t           sts_o,
  input  logic [tpd_pkg::OP_W-1:0]    opcode_i,
  input  logic                        submit_phase_i,
  input  logic [tpd_pkg::IDX_W-1:0]   submit_index_i,
  input  logic [tpd_pkg::CNT_W-1:0]   map_cnt_i,
  input  logic [tpd_pkg::CNT_W-1:0]   red_cnt_i,
  input  logic [tpd_pkg::TMO_W-1:0]   timeout_i,
  output logic [tpd_pkg::KIND_W-1:0]  grant_kind_o,
  output logic [tpd_pkg::IDX_W-1:0]   grant_index_o,
  output logic                        map_phase_done_o,
  output logic                        reduce_phase_done_o
);
  import tpd_pkg::*;

  // captured item
  logic [OP_W-1:0]      op_q;
  logic                 sub_phase_q;
  logic [IDX_W-1:0]     sub_idx_q;

  logic [TIME_W-1:0]    time_q;
  logic [MAX_TASKS-1:0] map_asg_q, map_cmp_q, red_asg_q, red_cmp_q;
  logic [CNT_W-1:0]     map_done_q, red_done_q;

  logic [TIME_W-1:0]    map_stamp_mem [MAX_TASKS];
  logic [TIME_W-1:0]    red_stamp_mem [MAX_TASKS];
  logic [TIME_W-1:0]    map_rd_q, red_rd_q;

  logic                 phase_q;  // 0 map table, 1 reduce table
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [KIND_W-1:0]    res_kind_q;
  logic [IDX_W-1:0]     res_idx_q;

  logic [KIND_W-1:0]    out_kind_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic                 out_map_done_q, out_red_done_q;

  logic [CNT_W-1:0]     map_eff, red_eff, scan_cnt, sub_cnt;
  logic                 map_pend, red_pend;
  logic                 cur_cmp, cur_asg, stale, sub_ok;
  logic [TIME_W-1:0]    cur_stamp, elapsed;

  assign map_eff  = (map_cnt_i > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : map_cnt_i;
  assign red_eff  = (red_cnt_i > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : red_cnt_i;
  assign map_pend = map_done_q < map_eff;
  assign red_pend = red_done_q < red_eff;

  assign scan_cnt  = phase_q ? red_eff : map_eff;
  assign cur_cmp   = phase_q ? red_cmp_q[idx_q] : map_cmp_q[idx_q];
  assign cur_asg   = phase_q ? red_asg_q[idx_q] : map_asg_q[idx_q];
  assign cur_stamp = phase_q ? red_rd_q : map_rd_q;
  assign elapsed   = time_q - cur_stamp;
  assign stale     = elapsed > TIME_W'(timeout_i);

  assign sub_cnt = sub_phase_q ? red_eff : map_eff;
  assign sub_ok  = CNT_W'(sub_idx_q) < sub_cnt;

  assign sts_o.is_ask  = (op_q == OP_ASK);
  assign sts_o.pending = map_pend | red_pend;
  assign sts_o.hit     = !cur_cmp && (!cur_asg || stale);
  assign sts_o.last    = (CNT_W'(idx_q) == scan_cnt - CNT_W'(1));

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.exec) begin
      idx_d = '0;
    end else if (cmd_i.inc_idx) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // stamp stores: read address runs one step ahead so the data lines up with idx_q
  always_ff @(posedge clk_i) begin
    map_rd_q <= map_stamp_mem[idx_d];
    if (cmd_i.grant && !phase_q) begin
      map_stamp_mem[idx_q] <= time_q;
    end
  end

  always_ff @(posedge clk_i) begin
    red_rd_q <= red_stamp_mem[idx_d];
    if (cmd_i.grant && phase_q) begin
      red_stamp_mem[idx_q] <= time_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q     <= '0;
      map_asg_q  <= '0;
      map_cmp_q  <= '0;
      red_asg_q  <= '0;
      red_cmp_q  <= '0;
      map_done_q <= '0;
      red_done_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        case (op_q)
          OP_TICK: time_q <= time_q + TIME_W'(1);
          OP_SUBMIT: begin
            if (sub_ok) begin
              if (!sub_phase_q && !map_cmp_q[sub_idx_q]) begin
                map_cmp_q[sub_idx_q] <= 1'b1;
                map_done_q           <= map_done_q + CNT_W'(1);
              end else if (sub_phase_q && !red_cmp_q[sub_idx_q]) begin
                red_cmp_q[sub_idx_q] <= 1'b1;
                red_done_q           <= red_done_q + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.grant) begin
        if (phase_q) begin
          red_asg_q[idx_q] <= 1'b1;
        end else begin
          map_asg_q[idx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q        <= opcode_i;
      sub_phase_q <= submit_phase_i;
      sub_idx_q   <= submit_index_i;
    end
    idx_q <= idx_d;
    if (cmd_i.exec) begin
      phase_q    <= !map_pend;
      res_kind_q <= KIND_NONE;
      res_idx_q  <= '0;
    end
    if (cmd_i.grant) begin
      res_kind_q <= phase_q ? KIND_REDUCE : KIND_MAP;
      res_idx_q  <= idx_q;
    end
    if (cmd_i.load_out) begin
      out_kind_q     <= res_kind_q;
      out_idx_q      <= res_idx_q;
      out_map_done_q <= !map_pend;
      out_red_done_q <= !red_pend;
    end
  end

  assign grant_kind_o        = out_kind_q;
  assign grant_index_o       = out_idx_q;
  assign map_phase_done_o    = out_map_done_q;
  assign reduce_phase_done_o = out_red_done_q;

endmodule

### rtl/two_phase_task_dispatcher_top.sv
// channel | signals                                        | direction
// --------+------------------------------------------------+----------
// in      | in_valid_i/in_ready_o, opcode_i, submit_phase_i,| item in
//         | submit_index_i                                 |
// out     | out_valid_o/out_ready_i, grant_kind_o,         | item out
//         | grant_index_o, map_phase_done_o,               |
//         | reduce_phase_done_o                            |
// apb     | psel, penable, pwrite, paddr, pwdata, prdata,  | config
//         | pready                                         |
//
// One item at a time. Tick, submit and asks that find no pending phase pass
// through the exec and done states; the next item is taken once the result
// is loaded. An ask with a pending phase also visits n entries (1..64) in the
// one-entry-per-cycle table scan of the phase that is still pending.
// Reset clears the time, assigned/completed bits and done counts at once; no
// clearing pass. A result held by out_ready_i low holds the next result back
// while the item behind it is already accepted and worked on.
module two_phase_task_dispatcher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tpd_pkg::OP_W-1:0]    opcode_i,
  input  logic                        submit_phase_i,
  input  logic [tpd_pkg::IDX_W-1:0]   submit_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tpd_pkg::KIND_W-1:0]  grant_kind_o,
  output logic [tpd_pkg::IDX_W-1:0]   grant_index_o,
  output logic                        map_phase_done_o,
  output logic                        reduce_phase_done_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpd_pkg::DATA_W-1:0]  pwdata,
  output logic [tpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tpd_pkg::*;

  tpd_cmd_t         cmd;
  tpd_sts_t         sts;
  logic [CNT_W-1:0] map_cnt, red_cnt;
  logic [TMO_W-1:0] timeout;

  tpd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .map_cnt_o (map_cnt),
    .red_cnt_o (red_cnt),
    .timeout_o (timeout)
  );

  tpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpd_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .opcode_i            (opcode_i),
    .submit_phase_i      (submit_phase_i),
    .submit_index_i      (submit_index_i),
    .map_cnt_i           (map_cnt),
    .red_cnt_i           (red_cnt),
    .timeout_i           (timeout),
    .grant_kind_o        (grant_kind_o),
    .grant_index_o       (grant_index_o),
    .map_phase_done_o    (map_phase_done_o),
    .reduce_phase_done_o (reduce_phase_done_o)
  );

endmodule

### rtl/tpd_checker.sv
module tpd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tpd_pkg::KIND_W-1:0]  grant_kind_o,
  input logic [tpd_pkg::IDX_W-1:0]   grant_index_o,
  input logic                        pready
);
  import tpd_pkg::*;

  // one item in flight: acceptance closes the input until the result is built
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (grant_kind_o != KIND_BAD))
    else $error("illegal grant kind");

  a_none_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && grant_kind_o == KIND_NONE) |-> (grant_index_o == '0))
    else $error("nonzero index without a grant");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(grant_kind_o) && $stable(grant_index_o)))
    else $error("stalled item changed or dropped");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind two_phase_task_dispatcher_top tpd_checker u_tpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .grant_kind_o  (grant_kind_o),
  .grant_index_o (grant_index_o),
  .pready        (pready)
);
